// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define QEA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qea assertion failed");

// Next-cycle implication
`define QEA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qea assertion failed");

`else

`define QEA_ASSERT_IMP(label, ante, cons)
`define QEA_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/qea_pkg.sv =====
// ----------------------------------------------------------------------------
// qea_pkg
// Shared constants, operation codes and term tables of the quadric accumulator.
// ----------------------------------------------------------------------------
package qea_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 14;
    localparam int NORM_FRAC = 14;
    localparam int ADD_SHIFT = 2 * NORM_FRAC - FRAC_BITS;
    localparam int NUM_COEF  = 10;
    localparam int IDX_W     = $clog2(NUM_COEF);

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_DMUL,
        OP_FMUL,
        OP_SMUL,
        OP_LO,
        OP_HI,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t  op;
        idx_t idx;
    } dp_cmd_t;

    // operand sources of an evaluate monomial
    typedef enum logic [1:0] {
        SEL_X,
        SEL_Y,
        SEL_Z,
        SEL_ONE
    } sel_t;

    typedef struct packed {
        sel_t u;
        sel_t v;
        logic dbl;
    } mono_t;

    // first factor of plane term k (0..2 normal, 3 is d)
    function automatic logic [1:0] pair_a(idx_t k);
        logic [1:0] r;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd5, 4'd6:       r = 2'd1;
            4'd7, 4'd8:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    // second factor of plane term k
    function automatic logic [1:0] pair_b(idx_t k);
        logic [1:0] r;
        case (k)
            4'd0:                   r = 2'd0;
            4'd1, 4'd4:             r = 2'd1;
            4'd2, 4'd5, 4'd7:       r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    // monomial of the quadratic form paired with coefficient k
    function automatic mono_t mono(idx_t k);
        mono_t m;
        case (k)
            4'd0:    m = '{u: SEL_X,   v: SEL_X,   dbl: 1'b0};
            4'd1:    m = '{u: SEL_X,   v: SEL_Y,   dbl: 1'b1};
            4'd2:    m = '{u: SEL_X,   v: SEL_Z,   dbl: 1'b1};
            4'd3:    m = '{u: SEL_X,   v: SEL_ONE, dbl: 1'b1};
            4'd4:    m = '{u: SEL_Y,   v: SEL_Y,   dbl: 1'b0};
            4'd5:    m = '{u: SEL_Y,   v: SEL_Z,   dbl: 1'b1};
            4'd6:    m = '{u: SEL_Y,   v: SEL_ONE, dbl: 1'b1};
            4'd7:    m = '{u: SEL_Z,   v: SEL_Z,   dbl: 1'b0};
            4'd8:    m = '{u: SEL_Z,   v: SEL_ONE, dbl: 1'b1};
            default: m = '{u: SEL_ONE, v: SEL_ONE, dbl: 1'b0};
        endcase
        return m;
    endfunction

    // magnitude of a 16-bit signed value
    function automatic logic [15:0] mag16(logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

// ===== hdl/qea_ctrl.sv =====
// ----------------------------------------------------------------------------
// qea_ctrl
// Sequencer: steps the datapath through clear, add-plane and evaluate.
// ----------------------------------------------------------------------------
module qea_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       command,
    output logic             busy,
    output qea_pkg::dp_cmd_t cmd
);
    import qea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DMUL,
        S_DWAIT,
        S_FMUL,
        S_FDRAIN,
        S_ES,
        S_ELO,
        S_EHI,
        S_EWAIT,
        S_EFIN
    } state_t;

    state_t state_reg, state_next;
    idx_t   cnt_reg, cnt_next;
    logic   busy_reg;

    localparam idx_t LAST_D    = IDX_W'(2);
    localparam idx_t LAST_TERM = IDX_W'(NUM_COEF - 1);
    localparam idx_t LAST_DRN  = IDX_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (start && command == CMD_ADD)
                    state_next = S_DMUL;
                else if (start && command == CMD_EVAL)
                    state_next = S_ES;
            end
            S_DMUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_D)
                    state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                cnt_next   = '0;
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TERM)
                begin
                    cnt_next   = '0;
                    state_next = S_FDRAIN;
                end
            end
            S_FDRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_DRN)
                    state_next = S_IDLE;
            end
            S_ES:    state_next = S_ELO;
            S_ELO:   state_next = S_EHI;
            S_EHI:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_TERM)
                    state_next = S_EWAIT;
                else
                    state_next = S_ES;
            end
            S_EWAIT: state_next = S_EFIN;
            S_EFIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath command decode
    always_comb
    begin
        cmd.idx = cnt_reg;
        cmd.op  = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command == CMD_CLEAR)
                    cmd.op = OP_CLEAR;
                else if (start && (command == CMD_ADD || command == CMD_EVAL))
                    cmd.op = OP_LOAD;
            end
            S_DMUL:  cmd.op = OP_DMUL;
            S_FMUL:  cmd.op = OP_FMUL;
            S_ES:    cmd.op = OP_SMUL;
            S_ELO:   cmd.op = OP_LO;
            S_EHI:   cmd.op = OP_HI;
            S_EFIN:  cmd.op = OP_FIN;
            default: cmd.op = OP_NONE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hdl/qea_dp.sv =====
// ----------------------------------------------------------------------------
// qea_dp
// Datapath: coefficient registers, shared 32x32 multiplier, area scaler,
// rounding/saturation and the 128-bit evaluate accumulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qea_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  qea_pkg::dp_cmd_t   cmd,
    input  logic signed [15:0] normal_a,
    input  logic signed [15:0] normal_b,
    input  logic signed [15:0] normal_c,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic [15:0]        area,
    output logic               done,
    output logic signed [63:0] cost,
    output logic               saturated
);
    import qea_pkg::*;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_D,
        TAG_F,
        TAG_LO,
        TAG_HI
    } tag_t;

    localparam logic [80:0] RND_HALF = 81'(1) << (ADD_SHIFT - 1);

    // operand latches
    logic signed [15:0] na_reg, nb_reg, nc_reg, px_reg, py_reg, pz_reg;
    logic [15:0]        area_reg;

    // state
    logic [63:0]        coef_reg [NUM_COEF];
    logic               ovf_reg, ovf_next;

    // pipeline
    logic signed [33:0] d_reg, d_next;
    logic [63:0]        mul_reg;
    logic               mul_neg_reg;
    tag_t               mul_tag_reg;
    idx_t               mul_idx_reg;
    logic [79:0]        ar_reg;
    logic               ar_neg_reg, ar_vld_reg;
    idx_t               ar_idx_reg;
    logic [31:0]        s_mag_reg;
    logic               s_neg_reg;
    logic [127:0]       acc_reg, acc_next;
    logic               done_reg, sat_reg;
    logic [63:0]        cost_reg;

    // shared multiplier operands
    logic [31:0]        op_a, op_b;
    logic               op_neg;
    logic [63:0]        prod;
    logic [79:0]        ar_prod;

    // plane factor magnitudes and signs (a, b, c, d)
    logic [31:0]        fmag [4];
    logic               fneg [4];
    logic signed [33:0] d_abs;
    mono_t              m;
    logic [15:0]        um, vm;
    logic               un, vn;

    // coefficient read port
    idx_t               rd_idx;
    logic [63:0]        coef_rd, cmag;

    // add-term rounding and saturating accumulate
    logic [80:0]        rnd_sum, r81;
    logic [63:0]        lim, term, sum;
    logic               term_ovf, add_ovf;
    logic [63:0]        coef_wr;

    // evaluate partial product
    logic [127:0]       p128;
    logic               fits;

    assign d_abs   = d_reg[33] ? -d_reg : d_reg;
    assign fmag[0] = {16'b0, mag16(na_reg)};
    assign fmag[1] = {16'b0, mag16(nb_reg)};
    assign fmag[2] = {16'b0, mag16(nc_reg)};
    assign fmag[3] = d_abs[31:0];
    assign fneg[0] = na_reg[15];
    assign fneg[1] = nb_reg[15];
    assign fneg[2] = nc_reg[15];
    assign fneg[3] = d_reg[33];

    assign rd_idx  = ar_vld_reg ? ar_idx_reg : cmd.idx;
    assign coef_rd = coef_reg[rd_idx];
    assign cmag    = coef_rd[63] ? 64'(-coef_rd) : coef_rd;

    // monomial factor selection
    assign m = mono(cmd.idx);
    always_comb
    begin
        case (m.u)
            SEL_X:   begin um = mag16(px_reg); un = px_reg[15]; end
            SEL_Y:   begin um = mag16(py_reg); un = py_reg[15]; end
            SEL_Z:   begin um = mag16(pz_reg); un = pz_reg[15]; end
            default: begin um = 16'd1;         un = 1'b0;       end
        endcase
        case (m.v)
            SEL_X:   begin vm = mag16(px_reg); vn = px_reg[15]; end
            SEL_Y:   begin vm = mag16(py_reg); vn = py_reg[15]; end
            SEL_Z:   begin vm = mag16(pz_reg); vn = pz_reg[15]; end
            default: begin vm = 16'd1;         vn = 1'b0;       end
        endcase
    end

    // multiplier operand mux
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        case (cmd.op)
            OP_DMUL:
            begin
                case (cmd.idx[1:0])
                    2'd0:    begin op_a = fmag[0]; op_b = {16'b0, mag16(px_reg)};
                                   op_neg = na_reg[15] ^ px_reg[15]; end
                    2'd1:    begin op_a = fmag[1]; op_b = {16'b0, mag16(py_reg)};
                                   op_neg = nb_reg[15] ^ py_reg[15]; end
                    default: begin op_a = fmag[2]; op_b = {16'b0, mag16(pz_reg)};
                                   op_neg = nc_reg[15] ^ pz_reg[15]; end
                endcase
            end
            OP_FMUL:
            begin
                op_a   = fmag[pair_a(cmd.idx)];
                op_b   = fmag[pair_b(cmd.idx)];
                op_neg = fneg[pair_a(cmd.idx)] ^ fneg[pair_b(cmd.idx)];
            end
            OP_SMUL:
            begin
                op_a   = {16'b0, um};
                op_b   = {16'b0, vm};
                op_neg = un ^ vn;
            end
            OP_LO:
            begin
                op_a   = s_mag_reg;
                op_b   = cmag[31:0];
                op_neg = s_neg_reg ^ coef_rd[63];
            end
            OP_HI:
            begin
                op_a   = s_mag_reg;
                op_b   = cmag[63:32];
                op_neg = s_neg_reg ^ coef_rd[63];
            end
            default: ;
        endcase
    end

    assign prod    = op_a * op_b;
    assign ar_prod = mul_reg * area_reg;

    // d = -(n.p), accumulated from each registered product
    always_comb
    begin
        d_next = d_reg;
        if (mul_tag_reg == TAG_D)
        begin
            if (mul_neg_reg)
                d_next = d_reg + $signed({2'b0, mul_reg[31:0]});
            else
                d_next = d_reg - $signed({2'b0, mul_reg[31:0]});
        end
    end

    // evaluate accumulation of signed partial products
    always_comb
    begin
        p128     = (mul_tag_reg == TAG_HI) ? {32'b0, mul_reg, 32'b0} : {64'b0, mul_reg};
        acc_next = acc_reg;
        if (mul_tag_reg == TAG_LO || mul_tag_reg == TAG_HI)
            acc_next = mul_neg_reg ? acc_reg - p128 : acc_reg + p128;
    end

    // plane term: round to nearest, ties away, then saturating accumulate
    always_comb
    begin
        rnd_sum  = {1'b0, ar_reg} + RND_HALF;
        r81      = rnd_sum >> ADD_SHIFT;
        lim      = ar_neg_reg ? SMIN : SMAX;
        term_ovf = (r81[80:64] != '0) || (r81[63:0] > lim);
        if (term_ovf)
            term = lim;
        else
            term = ar_neg_reg ? 64'(-r81[63:0]) : r81[63:0];
        sum     = coef_rd + term;
        add_ovf = (coef_rd[63] == term[63]) && (sum[63] != coef_rd[63]);
        coef_wr = add_ovf ? (coef_rd[63] ? SMIN : SMAX) : sum;
    end

    assign fits = (acc_reg[127:64] == {64{acc_reg[63]}});

    // sticky overflow flag
    always_comb
    begin
        ovf_next = ovf_reg;
        if (cmd.op == OP_CLEAR)
            ovf_next = 1'b0;
        else if (ar_vld_reg)
            ovf_next = ovf_reg | term_ovf | add_ovf;
        else if (cmd.op == OP_FIN)
            ovf_next = ovf_reg | !fits;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= '0;
            ovf_reg     <= 1'b0;
            mul_tag_reg <= TAG_NONE;
            ar_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            ovf_reg  <= ovf_next;
            done_reg <= (cmd.op == OP_FIN);
            if (cmd.op == OP_CLEAR)
            begin
                for (int i = 0; i < NUM_COEF; i++)
                    coef_reg[i] <= '0;
            end
            else if (ar_vld_reg)
                coef_reg[ar_idx_reg] <= coef_wr;

            case (cmd.op)
                OP_DMUL: mul_tag_reg <= TAG_D;
                OP_FMUL: mul_tag_reg <= TAG_F;
                OP_LO:   mul_tag_reg <= TAG_LO;
                OP_HI:   mul_tag_reg <= TAG_HI;
                default: mul_tag_reg <= TAG_NONE;
            endcase
            ar_vld_reg <= (mul_tag_reg == TAG_F);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            na_reg   <= normal_a;
            nb_reg   <= normal_b;
            nc_reg   <= normal_c;
            px_reg   <= point_x;
            py_reg   <= point_y;
            pz_reg   <= point_z;
            area_reg <= area;
            d_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            d_reg   <= d_next;
            acc_reg <= acc_next;
        end
        mul_reg     <= prod;
        mul_neg_reg <= op_neg;
        mul_idx_reg <= cmd.idx;
        ar_reg      <= ar_prod;
        ar_neg_reg  <= mul_neg_reg;
        ar_idx_reg  <= mul_idx_reg;
        if (cmd.op == OP_SMUL)
        begin
            s_mag_reg <= m.dbl ? {prod[30:0], 1'b0} : prod[31:0];
            s_neg_reg <= op_neg;
        end
        if (cmd.op == OP_FIN)
        begin
            cost_reg <= fits ? acc_reg[63:0] : (acc_reg[127] ? SMIN : SMAX);
            sat_reg  <= ovf_reg | !fits;
        end
    end

    assign done      = done_reg;
    assign cost      = $signed(cost_reg);
    assign saturated = sat_reg;

    // checks
    `QEA_ASSERT_NXT(a_fin_gives_done, cmd.op == OP_FIN, done_reg)
    `QEA_ASSERT_IMP(a_flag_matches, done_reg, sat_reg == ovf_reg)
    `QEA_ASSERT_NXT(a_term_from_fmul, mul_tag_reg == TAG_F, ar_vld_reg)
    `QEA_ASSERT_IMP(a_lo_then_hi, mul_tag_reg == TAG_LO, cmd.op == OP_HI)

endmodule

// ===== hdl/quadric_error_accumulator.sv =====
// Add-plane: busy after the start transfer; clear is done from idle and raises no busy.
// Evaluate: the cost appears together with done.
// Rate is set by the single shared 32x32 multiplier (one pass per term on add,
// three passes per coefficient on evaluate).
// done strobes for one cycle; the receiver cannot stall; cost and saturated hold until the next evaluate.
// Reset (rst_n low, async) zeroes all ten coefficients and the overflow flag.
// ----------------------------------------------------------------------------
// quadric_error_accumulator
// Top level: plane quadric accumulator with saturating fixed-point cost.
// ----------------------------------------------------------------------------
module quadric_error_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [15:0] normal_a,
    input  logic signed [15:0] normal_b,
    input  logic signed [15:0] normal_c,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic signed [15:0] point_z,
    input  logic [15:0]        area,
    output logic               done,
    output logic signed [63:0] cost,
    output logic               saturated
);
    import qea_pkg::*;

    dp_cmd_t dp_cmd;
    logic    busy_int;

    // sequencer
    qea_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy_int),
        .cmd     (dp_cmd)
    );

    // arithmetic and storage
    qea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .normal_a  (normal_a),
        .normal_b  (normal_b),
        .normal_c  (normal_c),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .area      (area),
        .done      (done),
        .cost      (cost),
        .saturated (saturated)
    );

    assign busy = busy_int;

endmodule
